FILE: hdl/directional_focus_navigator_assert.svh
// assertion macros shared by the focus navigator modules
// expects clk_i and rst_ni in the including module
`ifndef DIRECTIONAL_FOCUS_NAVIGATOR_ASSERT_SVH
`define DIRECTIONAL_FOCUS_NAVIGATOR_ASSERT_SVH

// same-cycle implication
`define DFN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dfn_pkg.sv
// shared types and constants of the directional focus navigator
// no dependencies
package dfn_pkg;

  localparam int MAX_TARGETS = 64;
  localparam int IDX_W       = $clog2(MAX_TARGETS);
  localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
  localparam int ID_W        = 16;
  localparam int POS_W       = 16;
  localparam int SIZE_W      = 15;
  localparam int NAV_W       = 4;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = SQ_W + 1;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    WALK_FIND = 2'd0,
    WALK_STEP = 2'd1,
    WALK_OVER = 2'd2
  } walk_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_WALK,
    ST_FIND_DRAIN,
    ST_REHOME,
    ST_DIR_CHECK,
    ST_FROM_RD,
    ST_FROM_WAIT,
    ST_STEP_WALK,
    ST_STEP_DRAIN,
    ST_STEP_APPLY,
    ST_OVER_WALK,
    ST_OVER_DRAIN,
    ST_FINISH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [SIZE_W-1:0]        w;
    logic [SIZE_W-1:0]        h;
  } slot_t;

  typedef struct packed {
    logic             snap_load;
    logic             list_clear;
    logic             add_write;
    logic             rd_en;
    logic             from_rd;
    logic [IDX_W-1:0] rd_addr;
    walk_e            mode;
    dir_e             dir;
    logic             walk_init;
    logic             rehome;
    logic             resolve_init;
    logic             step_apply;
    logic             finish;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [NAV_W-1:0] nav_edge;
    logic             cur_valid;
    logic             resolved;
    logic             busy;
    logic             out_free;
  } ctrl_sts_t;

endpackage

FILE: hdl/dfn_if.sv
// valid/ready channel interfaces for the navigator input and result
// depends on dfn_pkg
interface dfn_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic [dfn_pkg::ID_W-1:0]             target_id;
  logic signed [dfn_pkg::POS_W-1:0]     pos_x;
  logic signed [dfn_pkg::POS_W-1:0]     pos_y;
  logic [dfn_pkg::SIZE_W-1:0]           size_w;
  logic [dfn_pkg::SIZE_W-1:0]           size_h;
  logic                                 button_primary;
  logic [dfn_pkg::NAV_W-1:0]            nav_bits;
  logic                                 confirm_held;
  logic                                 cancel_held;

  modport source (
    output valid, cmd, target_id, pos_x, pos_y, size_w, size_h,
           button_primary, nav_bits, confirm_held, cancel_held,
    input  ready
  );
  modport sink (
    input  valid, cmd, target_id, pos_x, pos_y, size_w, size_h,
           button_primary, nav_bits, confirm_held, cancel_held,
    output ready
  );
endinterface

interface dfn_out_if;
  logic                     valid;
  logic                     ready;
  logic [dfn_pkg::ID_W-1:0] current_id;
  logic                     has_focus;
  logic [dfn_pkg::ID_W-1:0] confirmed_id;
  logic                     has_confirm;
  logic                     cancel_edge;
  logic                     list_overflow;

  modport source (
    output valid, current_id, has_focus, confirmed_id, has_confirm,
           cancel_edge, list_overflow,
    input  ready
  );
  modport sink (
    input  valid, current_id, has_focus, confirmed_id, has_confirm,
           cancel_edge, list_overflow,
    output ready
  );
endinterface

FILE: hdl/dfn_ctrl.sv
// sequencer of the focus navigator: table walks and resolve steps
// depends on dfn_pkg and the assertion header
`include "directional_focus_navigator_assert.svh"

module dfn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_cmd_i,
  output logic               in_ready_o,
  input  dfn_pkg::ctrl_sts_t sts_i,
  output dfn_pkg::ctrl_cmd_t cmd_o
);

  dfn_pkg::state_e              state_q, state_d;
  logic [dfn_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [2:0]                   dir_q, dir_d;
  logic                         last_idx;
  logic                         accept;
  dfn_pkg::cmd_e                op;

  assign op       = dfn_pkg::cmd_e'(in_cmd_i);
  assign accept   = in_valid_i && (state_q == dfn_pkg::ST_IDLE);
  assign last_idx = ({1'b0, idx_q} == (sts_i.count - dfn_pkg::CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfn_pkg::ST_IDLE;
      idx_q   <= '0;
      dir_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dir_q   <= dir_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    dir_d      = dir_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_addr = idx_q;
    cmd_o.dir     = dfn_pkg::dir_e'(dir_q[1:0]);
    cmd_o.mode    = dfn_pkg::WALK_FIND;

    unique case (state_q)
      dfn_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (op)
            dfn_pkg::CMD_SAMPLE: cmd_o.snap_load  = 1'b1;
            dfn_pkg::CMD_BEGIN:  cmd_o.list_clear = 1'b1;
            dfn_pkg::CMD_ADD:    cmd_o.add_write  = 1'b1;
            dfn_pkg::CMD_END: begin
              cmd_o.walk_init = 1'b1;
              idx_d   = '0;
              state_d = (sts_i.count != '0) ? dfn_pkg::ST_FIND_WALK : dfn_pkg::ST_REHOME;
            end
            default: ;
          endcase
        end
      end
      dfn_pkg::ST_FIND_WALK: begin
        cmd_o.rd_en = 1'b1;
        if (last_idx) state_d = dfn_pkg::ST_FIND_DRAIN;
        else idx_d = idx_q + dfn_pkg::IDX_W'(1);
      end
      dfn_pkg::ST_FIND_DRAIN: begin
        if (!sts_i.busy) state_d = dfn_pkg::ST_REHOME;
      end
      dfn_pkg::ST_REHOME: begin
        cmd_o.rehome = 1'b1;
        if (sts_i.resolved) begin
          state_d = dfn_pkg::ST_RESULT;
        end else begin
          cmd_o.resolve_init = 1'b1;
          dir_d   = '0;
          state_d = dfn_pkg::ST_DIR_CHECK;
        end
      end
      dfn_pkg::ST_DIR_CHECK: begin
        if (dir_q[2]) begin
          cmd_o.walk_init = 1'b1;
          cmd_o.mode      = dfn_pkg::WALK_OVER;
          idx_d   = '0;
          state_d = (sts_i.count != '0) ? dfn_pkg::ST_OVER_WALK : dfn_pkg::ST_FINISH;
        end else if (sts_i.nav_edge[dir_q[1:0]] && sts_i.cur_valid) begin
          state_d = dfn_pkg::ST_FROM_RD;
        end else begin
          dir_d = dir_q + 3'd1;
        end
      end
      dfn_pkg::ST_FROM_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.from_rd = 1'b1;
        cmd_o.mode    = dfn_pkg::WALK_STEP;
        state_d = dfn_pkg::ST_FROM_WAIT;
      end
      dfn_pkg::ST_FROM_WAIT: begin
        cmd_o.walk_init = 1'b1;
        cmd_o.mode      = dfn_pkg::WALK_STEP;
        idx_d   = '0;
        state_d = dfn_pkg::ST_STEP_WALK;
      end
      dfn_pkg::ST_STEP_WALK: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.mode  = dfn_pkg::WALK_STEP;
        if (last_idx) state_d = dfn_pkg::ST_STEP_DRAIN;
        else idx_d = idx_q + dfn_pkg::IDX_W'(1);
      end
      dfn_pkg::ST_STEP_DRAIN: begin
        cmd_o.mode = dfn_pkg::WALK_STEP;
        if (!sts_i.busy) state_d = dfn_pkg::ST_STEP_APPLY;
      end
      dfn_pkg::ST_STEP_APPLY: begin
        cmd_o.step_apply = 1'b1;
        cmd_o.mode       = dfn_pkg::WALK_STEP;
        dir_d   = dir_q + 3'd1;
        state_d = dfn_pkg::ST_DIR_CHECK;
      end
      dfn_pkg::ST_OVER_WALK: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.mode  = dfn_pkg::WALK_OVER;
        if (last_idx) state_d = dfn_pkg::ST_OVER_DRAIN;
        else idx_d = idx_q + dfn_pkg::IDX_W'(1);
      end
      dfn_pkg::ST_OVER_DRAIN: begin
        cmd_o.mode = dfn_pkg::WALK_OVER;
        if (!sts_i.busy) state_d = dfn_pkg::ST_FINISH;
      end
      dfn_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = dfn_pkg::ST_RESULT;
      end
      dfn_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = dfn_pkg::ST_IDLE;
        end
      end
      default: state_d = dfn_pkg::ST_IDLE;
    endcase
  end

  `DFN_ASSERT_NEXT(a_end_leaves_idle,
    in_valid_i && in_ready_o && (in_cmd_i == dfn_pkg::CMD_END),
    state_q != dfn_pkg::ST_IDLE, "end transaction did not start a walk")
  `DFN_ASSERT_NOW(a_walk_in_range, cmd_o.rd_en && !cmd_o.from_rd,
    {1'b0, cmd_o.rd_addr} < sts_i.count, "walk address beyond table fill")
  `DFN_ASSERT_NOW(a_load_when_free, cmd_o.out_load, sts_i.out_free,
    "result loaded over a pending transaction")

endmodule

FILE: hdl/dfn_dp.sv
// datapath of the focus navigator: target memory, walk pipeline, focus state
// depends on dfn_pkg and the assertion header
`include "directional_focus_navigator_assert.svh"

module dfn_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dfn_pkg::ctrl_cmd_t               cmd_i,
  output dfn_pkg::ctrl_sts_t               sts_o,
  input  logic [dfn_pkg::ID_W-1:0]         target_id_i,
  input  logic signed [dfn_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [dfn_pkg::POS_W-1:0] pos_y_i,
  input  logic [dfn_pkg::SIZE_W-1:0]       size_w_i,
  input  logic [dfn_pkg::SIZE_W-1:0]       size_h_i,
  input  logic                             button_primary_i,
  input  logic [dfn_pkg::NAV_W-1:0]        nav_bits_i,
  input  logic                             confirm_held_i,
  input  logic                             cancel_held_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [dfn_pkg::ID_W-1:0]         current_id_o,
  output logic                             has_focus_o,
  output logic [dfn_pkg::ID_W-1:0]         confirmed_id_o,
  output logic                             has_confirm_o,
  output logic                             cancel_edge_o,
  output logic                             list_overflow_o
);

  localparam int IW = dfn_pkg::IDX_W;
  localparam int CW = dfn_pkg::CNT_W;
  localparam int DW = dfn_pkg::ID_W;
  localparam int PW = dfn_pkg::POS_W;

  dfn_pkg::slot_t slot_mem [dfn_pkg::MAX_TARGETS];
  dfn_pkg::slot_t rd_q;

  logic [CW-1:0]          count_q;
  logic                   overflow_q;
  logic [DW-1:0]          focus_id_q, chosen_id_q, cur_id_q, best_id_q, slot0_id_q, b_id_q;
  logic                   focus_valid_q, chosen_valid_q, cancel_q, resolved_q;
  logic [IW-1:0]          cur_idx_q, best_idx_q, a_idx_q, b_idx_q, addr;
  logic                   cur_valid_q, best_valid_q;
  logic                   a_vld_q, a_from_q, b_vld_q, b_ok_q;
  logic [dfn_pkg::DIST_W-1:0] best_d_q;
  logic [dfn_pkg::SQ_W-1:0]   b_sqx_q, b_sqy_q;

  logic signed [PW-1:0]   now_x_q, now_y_q, prev_x_q, prev_y_q;
  logic [dfn_pkg::NAV_W-1:0] now_nav_q, prev_nav_q;
  logic                   now_btn_q, prev_btn_q, now_conf_q, prev_conf_q;
  logic                   now_can_q, prev_can_q;

  logic signed [PW-1:0]   f_x_q, f_y_q;
  logic [dfn_pkg::SIZE_W-1:0] f_w_q, f_h_q;

  logic                   out_valid_q;
  logic [DW-1:0]          out_cur_q, out_conf_q;
  logic                   out_focus_q, out_has_conf_q, out_cancel_q, out_ovf_q;

  // stage b signals
  logic signed [PW:0]     x_end, y_end, f_xe, f_ye, px, py, cx, cy, fx, fy;
  logic signed [PW+1:0]   gx1, gx2, gy1, gy2, gx, gy;
  logic [PW-1:0]          ux, uy;
  logic                   beyond, hit, ok;
  logic [dfn_pkg::DIST_W-1:0] gap_sq;
  logic                   take;
  logic                   moved, click, conf_edge;
  logic                   nc_vld, cf_vld;
  logic [DW-1:0]          nc_id, cf_id;
  logic                   out_free;

  assign addr = cmd_i.from_rd ? cur_idx_q : cmd_i.rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write && (count_q < CW'(dfn_pkg::MAX_TARGETS))) begin
      slot_mem[count_q[IW-1:0]] <= '{id: target_id_i, x: pos_x_i, y: pos_y_i,
                                     w: size_w_i, h: size_h_i};
    end
    if (cmd_i.rd_en) rd_q <= slot_mem[addr];
  end

  // geometry of the candidate against the focused rectangle and the pointer, and the match test of each walk mode
  always_comb begin
    cx    = {rd_q.x[PW-1], rd_q.x};
    cy    = {rd_q.y[PW-1], rd_q.y};
    fx    = {f_x_q[PW-1], f_x_q};
    fy    = {f_y_q[PW-1], f_y_q};
    x_end = cx + $signed({2'b00, rd_q.w});
    y_end = cy + $signed({2'b00, rd_q.h});
    f_xe  = fx + $signed({2'b00, f_w_q});
    f_ye  = fy + $signed({2'b00, f_h_q});
    px    = {now_x_q[PW-1], now_x_q};
    py    = {now_y_q[PW-1], now_y_q};
    gx1   = {fx[PW], fx} - {x_end[PW], x_end};
    gx2   = {cx[PW], cx} - {f_xe[PW], f_xe};
    gy1   = {fy[PW], fy} - {y_end[PW], y_end};
    gy2   = {cy[PW], cy} - {f_ye[PW], f_ye};
    gx    = (gx2 > gx1) ? gx2 : gx1;
    gy    = (gy2 > gy1) ? gy2 : gy1;
    ux    = gx[PW+1] ? '0 : gx[PW-1:0];
    uy    = gy[PW+1] ? '0 : gy[PW-1:0];
    unique case (cmd_i.dir)
      dfn_pkg::DIR_LEFT:  beyond = cx < fx;
      dfn_pkg::DIR_RIGHT: beyond = x_end > f_xe;
      dfn_pkg::DIR_UP:    beyond = cy < fy;
      dfn_pkg::DIR_DOWN:  beyond = y_end > f_ye;
      default:            beyond = 1'b0;
    endcase
    hit = (px >= cx) && (px < x_end) && (py >= cy) && (py < y_end);
    unique case (cmd_i.mode)
      dfn_pkg::WALK_FIND: ok = focus_valid_q && (rd_q.id == focus_id_q);
      dfn_pkg::WALK_STEP: ok = beyond && (a_idx_q != cur_idx_q);
      dfn_pkg::WALK_OVER: ok = hit;
      default:            ok = 1'b0;
    endcase
  end

  assign gap_sq = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};
  assign take = b_vld_q && b_ok_q &&
                (!best_valid_q || ((cmd_i.mode == dfn_pkg::WALK_STEP) && (gap_sq < best_d_q)));

  always_ff @(posedge clk_i) begin
    if (a_from_q) begin
      f_x_q <= rd_q.x;
      f_y_q <= rd_q.y;
      f_w_q <= rd_q.w;
      f_h_q <= rd_q.h;
    end
    b_id_q  <= rd_q.id;
    b_idx_q <= a_idx_q;
    b_sqx_q <= {{PW{1'b0}}, ux} * {{PW{1'b0}}, ux};
    b_sqy_q <= {{PW{1'b0}}, uy} * {{PW{1'b0}}, uy};
    if (take) begin
      best_idx_q <= b_idx_q;
      best_id_q  <= b_id_q;
      best_d_q   <= gap_sq;
    end
    if (b_vld_q && (b_idx_q == '0)) slot0_id_q <= b_id_q;
  end

  assign moved     = (now_x_q != prev_x_q) || (now_y_q != prev_y_q);
  assign click     = now_btn_q && !prev_btn_q;
  assign conf_edge = now_conf_q && !prev_conf_q;

  always_comb begin
    nc_vld = cur_valid_q;
    nc_id  = cur_id_q;
    cf_vld = 1'b0;
    cf_id  = cur_id_q;
    if ((moved || click) && best_valid_q) begin
      nc_vld = 1'b1;
      nc_id  = best_id_q;
    end
    if (click) begin
      cf_vld = best_valid_q;
      cf_id  = best_id_q;
    end else if (conf_edge) begin
      cf_vld = nc_vld;
      cf_id  = nc_id;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      overflow_q     <= 1'b0;
      focus_id_q     <= '0;
      focus_valid_q  <= 1'b0;
      chosen_id_q    <= '0;
      chosen_valid_q <= 1'b0;
      cancel_q       <= 1'b0;
      resolved_q     <= 1'b0;
      cur_idx_q      <= '0;
      cur_id_q       <= '0;
      cur_valid_q    <= 1'b0;
      best_valid_q   <= 1'b0;
      a_vld_q        <= 1'b0;
      a_idx_q        <= '0;
      a_from_q       <= 1'b0;
      b_vld_q        <= 1'b0;
      b_ok_q         <= 1'b0;
      now_x_q        <= '0;
      now_y_q        <= '0;
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      now_nav_q      <= '0;
      prev_nav_q     <= '0;
      now_btn_q      <= 1'b0;
      prev_btn_q     <= 1'b0;
      now_conf_q     <= 1'b0;
      prev_conf_q    <= 1'b0;
      now_can_q      <= 1'b0;
      prev_can_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      a_vld_q  <= cmd_i.rd_en && !cmd_i.from_rd;
      a_from_q <= cmd_i.rd_en && cmd_i.from_rd;
      a_idx_q  <= addr;
      b_vld_q  <= a_vld_q;
      b_ok_q   <= ok;

      if (cmd_i.walk_init) best_valid_q <= 1'b0;
      else if (take) best_valid_q <= 1'b1;

      if (cmd_i.snap_load) begin
        prev_x_q    <= now_x_q;
        prev_y_q    <= now_y_q;
        prev_nav_q  <= now_nav_q;
        prev_btn_q  <= now_btn_q;
        prev_conf_q <= now_conf_q;
        prev_can_q  <= now_can_q;
        now_x_q     <= pos_x_i;
        now_y_q     <= pos_y_i;
        now_nav_q   <= nav_bits_i;
        now_btn_q   <= button_primary_i;
        now_conf_q  <= confirm_held_i;
        now_can_q   <= cancel_held_i;
        resolved_q  <= 1'b0;
      end

      if (cmd_i.list_clear) begin
        count_q    <= '0;
        overflow_q <= 1'b0;
      end

      if (cmd_i.add_write) begin
        if (count_q < CW'(dfn_pkg::MAX_TARGETS)) count_q <= count_q + CW'(1);
        else overflow_q <= 1'b1;
      end

      if (cmd_i.rehome) begin
        if (focus_valid_q && best_valid_q) begin
          cur_idx_q   <= best_idx_q;
          cur_id_q    <= best_id_q;
          cur_valid_q <= 1'b1;
        end else if (count_q != '0) begin
          focus_id_q    <= slot0_id_q;
          focus_valid_q <= 1'b1;
          cur_idx_q     <= '0;
          cur_id_q      <= slot0_id_q;
          cur_valid_q   <= 1'b1;
        end else begin
          focus_valid_q <= 1'b0;
          cur_valid_q   <= 1'b0;
        end
      end

      if (cmd_i.resolve_init) begin
        resolved_q     <= 1'b1;
        chosen_valid_q <= 1'b0;
        cancel_q       <= now_can_q && !prev_can_q;
      end

      if (cmd_i.step_apply && best_valid_q) begin
        cur_idx_q <= best_idx_q;
        cur_id_q  <= best_id_q;
      end

      if (cmd_i.finish) begin
        focus_valid_q <= nc_vld;
        if (nc_vld) focus_id_q <= nc_id;
        if (cf_vld) begin
          chosen_valid_q <= 1'b1;
          chosen_id_q    <= cf_id;
        end
      end

      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_cur_q      <= focus_valid_q ? focus_id_q : '0;
      out_focus_q    <= focus_valid_q;
      out_conf_q     <= chosen_valid_q ? chosen_id_q : '0;
      out_has_conf_q <= chosen_valid_q;
      out_cancel_q   <= cancel_q;
      out_ovf_q      <= overflow_q;
    end
  end

  assign sts_o.count     = count_q;
  assign sts_o.nav_edge  = now_nav_q & ~prev_nav_q;
  assign sts_o.cur_valid = cur_valid_q;
  assign sts_o.resolved  = resolved_q;
  assign sts_o.busy      = a_vld_q || b_vld_q;
  assign sts_o.out_free  = out_free;

  assign out_valid_o     = out_valid_q;
  assign current_id_o    = out_cur_q;
  assign has_focus_o     = out_focus_q;
  assign confirmed_id_o  = out_conf_q;
  assign has_confirm_o   = out_has_conf_q;
  assign cancel_edge_o   = out_cancel_q;
  assign list_overflow_o = out_ovf_q;

  `DFN_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(dfn_pkg::MAX_TARGETS),
    "table fill beyond capacity")
  `DFN_ASSERT_NEXT(a_out_set, cmd_i.out_load, out_valid_q,
    "loaded result not presented")

endmodule

FILE: hdl/directional_focus_navigator.sv
// top level of the directional focus navigator
// depends on dfn_pkg, dfn_if, dfn_ctrl and dfn_dp
//
//  channel  | dir | payload
//  in_i     | in  | cmd, target_id, pos_x/y, size_w/h, button, nav, confirm, cancel
//  out_o    | out | current_id, has_focus, confirmed_id, has_confirm, cancel_edge, overflow
//
// sample, begin and add transactions are accepted in the idle state and leave it idle
// an end transaction walks the table once for the focus, once per new d-pad press and
// once for the pointer, one entry per cycle through the single read port of the target
// memory; with an empty table no walk is made
// reset is asynchronous; the table needs no clearing pass
// a result not yet taken holds the next end transaction in its last state, and input
// waits behind it; sample, begin and add before that end are still accepted
module directional_focus_navigator (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfn_in_if.sink    in_i,
  dfn_out_if.source out_o
);

  dfn_pkg::ctrl_cmd_t cmd;
  dfn_pkg::ctrl_sts_t sts;

  dfn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfn_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .target_id_i      (in_i.target_id),
    .pos_x_i          (in_i.pos_x),
    .pos_y_i          (in_i.pos_y),
    .size_w_i         (in_i.size_w),
    .size_h_i         (in_i.size_h),
    .button_primary_i (in_i.button_primary),
    .nav_bits_i       (in_i.nav_bits),
    .confirm_held_i   (in_i.confirm_held),
    .cancel_held_i    (in_i.cancel_held),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .current_id_o     (out_o.current_id),
    .has_focus_o      (out_o.has_focus),
    .confirmed_id_o   (out_o.confirmed_id),
    .has_confirm_o    (out_o.has_confirm),
    .cancel_edge_o    (out_o.cancel_edge),
    .list_overflow_o  (out_o.list_overflow)
  );

endmodule

FILE: dv/directional_focus_navigator_checker.sv
// checker for the directional focus navigator: watches both channels,
// predicts each result from accepted input transactions and compares field by field
// depends on dfn_pkg and dfn_if
module directional_focus_navigator_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dfn_in_if    in_if,
  dfn_out_if   out_if,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [dfn_pkg::ID_W-1:0] current_id;
    logic                     has_focus;
    logic [dfn_pkg::ID_W-1:0] confirmed_id;
    logic                     has_confirm;
    logic                     cancel_edge;
    logic                     list_overflow;
  } nav_result_t;

  typedef struct {
    longint                    x;
    longint                    y;
    logic                      btn;
    logic [dfn_pkg::NAV_W-1:0] nav;
    logic                      confirm;
    logic                      cancel;
  } snapshot_t;

  logic [dfn_pkg::ID_W-1:0] tbl_id [dfn_pkg::MAX_TARGETS];
  longint          tbl_x  [dfn_pkg::MAX_TARGETS];
  longint          tbl_y  [dfn_pkg::MAX_TARGETS];
  longint          tbl_w  [dfn_pkg::MAX_TARGETS];
  longint          tbl_h  [dfn_pkg::MAX_TARGETS];
  int              tbl_count;
  logic [dfn_pkg::ID_W-1:0] focus_id, chosen_id;
  logic            focus_valid, chosen_valid, cancel_seen, resolved, overflowed;
  snapshot_t       snap_now, snap_prev;
  nav_result_t     expected_q[$];
  int              fails;

  function automatic int slot_of(logic [dfn_pkg::ID_W-1:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int nearest_in_dir(int from, dfn_pkg::dir_e d);
    logic   horiz;
    longint sg, flo, fhi, beyond, lo, hi, gx, gy, g2, gap_d, best_d;
    int     best;
    horiz  = (d == dfn_pkg::DIR_LEFT || d == dfn_pkg::DIR_RIGHT);
    sg     = (d == dfn_pkg::DIR_RIGHT || d == dfn_pkg::DIR_DOWN) ? 1 : -1;
    best   = -1;
    best_d = -1;
    if (from < 0) return (tbl_count != 0) ? 0 : -1;
    flo    = sg * (horiz ? tbl_x[from] : tbl_y[from]);
    fhi    = sg * (horiz ? tbl_x[from] + tbl_w[from] : tbl_y[from] + tbl_h[from]);
    beyond = (flo > fhi) ? flo : fhi;
    for (int i = 0; i < tbl_count; i++) begin
      if (i == from) continue;
      lo = sg * (horiz ? tbl_x[i] : tbl_y[i]);
      hi = sg * (horiz ? tbl_x[i] + tbl_w[i] : tbl_y[i] + tbl_h[i]);
      if (((lo > hi) ? lo : hi) <= beyond) continue;
      gx = tbl_x[from] - (tbl_x[i] + tbl_w[i]);
      g2 = tbl_x[i] - (tbl_x[from] + tbl_w[from]);
      if (g2 > gx) gx = g2;
      gy = tbl_y[from] - (tbl_y[i] + tbl_h[i]);
      g2 = tbl_y[i] - (tbl_y[from] + tbl_h[from]);
      if (g2 > gy) gy = g2;
      if (gx < 0) gx = 0;
      if (gy < 0) gy = 0;
      gap_d = gx * gx + gy * gy;
      if (best_d < 0 || gap_d < best_d) begin
        best_d = gap_d;
        best   = i;
      end
    end
    return (best >= 0) ? best : from;
  endfunction

  function automatic void resolve_sample();
    int   cur, hover, conf;
    logic moved, click;
    hover = -1;
    conf  = -1;
    if (resolved) return;
    resolved     = 1'b1;
    chosen_valid = 1'b0;
    cancel_seen  = snap_now.cancel && !snap_prev.cancel;
    cur = focus_valid ? slot_of(focus_id) : -1;
    for (int d = 0; d < dfn_pkg::NAV_W; d++)
      if (snap_now.nav[d] && !snap_prev.nav[d]) cur = nearest_in_dir(cur, dfn_pkg::dir_e'(d));
    for (int i = 0; i < tbl_count; i++) begin
      if (snap_now.x >= tbl_x[i] && snap_now.x < tbl_x[i] + tbl_w[i] &&
          snap_now.y >= tbl_y[i] && snap_now.y < tbl_y[i] + tbl_h[i]) begin
        hover = i;
        break;
      end
    end
    moved = (snap_now.x != snap_prev.x) || (snap_now.y != snap_prev.y);
    if (moved && hover >= 0) cur = hover;
    click = snap_now.btn && !snap_prev.btn;
    if (click) begin
      if (hover >= 0) begin
        cur  = hover;
        conf = hover;
      end
    end else if (snap_now.confirm && !snap_prev.confirm) begin
      conf = cur;
    end
    if (cur >= 0) begin
      focus_id    = tbl_id[cur];
      focus_valid = 1'b1;
    end else begin
      focus_valid = 1'b0;
    end
    if (conf >= 0) begin
      chosen_id    = tbl_id[conf];
      chosen_valid = 1'b1;
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nav_result_t exp_r, got_r;
    if (!rst_ni) begin
      tbl_count    = 0;
      focus_id     = '0;
      focus_valid  = 1'b0;
      chosen_id    = '0;
      chosen_valid = 1'b0;
      cancel_seen  = 1'b0;
      resolved     = 1'b0;
      overflowed   = 1'b0;
      snap_now     = '{0, 0, 1'b0, '0, 1'b0, 1'b0};
      snap_prev    = snap_now;
      expected_q.delete();
      fails        = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        case (dfn_pkg::cmd_e'(in_if.cmd))
          dfn_pkg::CMD_SAMPLE: begin
            snap_prev        = snap_now;
            snap_now.x       = longint'(in_if.pos_x);
            snap_now.y       = longint'(in_if.pos_y);
            snap_now.btn     = in_if.button_primary;
            snap_now.nav     = in_if.nav_bits;
            snap_now.confirm = in_if.confirm_held;
            snap_now.cancel  = in_if.cancel_held;
            resolved         = 1'b0;
          end
          dfn_pkg::CMD_BEGIN: begin
            tbl_count  = 0;
            overflowed = 1'b0;
          end
          dfn_pkg::CMD_ADD: begin
            if (tbl_count >= dfn_pkg::MAX_TARGETS) begin
              overflowed = 1'b1;
            end else begin
              tbl_id[tbl_count] = in_if.target_id;
              tbl_x[tbl_count]  = longint'(in_if.pos_x);
              tbl_y[tbl_count]  = longint'(in_if.pos_y);
              tbl_w[tbl_count]  = longint'(in_if.size_w);
              tbl_h[tbl_count]  = longint'(in_if.size_h);
              tbl_count++;
            end
          end
          default: begin
            if (!focus_valid || slot_of(focus_id) < 0) begin
              if (tbl_count != 0) begin
                focus_id    = tbl_id[0];
                focus_valid = 1'b1;
              end else begin
                focus_valid = 1'b0;
              end
            end
            resolve_sample();
            exp_r.current_id    = focus_valid ? focus_id : '0;
            exp_r.has_focus     = focus_valid;
            exp_r.confirmed_id  = chosen_valid ? chosen_id : '0;
            exp_r.has_confirm   = chosen_valid;
            exp_r.cancel_edge   = cancel_seen;
            exp_r.list_overflow = overflowed;
            expected_q.push_back(exp_r);
          end
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got_r = '{out_if.current_id, out_if.has_focus, out_if.confirmed_id,
                  out_if.has_confirm, out_if.cancel_edge, out_if.list_overflow};
        if (expected_q.size() == 0) begin
          report("unexpected result transaction", got_r, 0);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r.current_id != exp_r.current_id)
            report("current_id", got_r.current_id, exp_r.current_id);
          if (got_r.has_focus != exp_r.has_focus)
            report("has_focus", got_r.has_focus, exp_r.has_focus);
          if (got_r.confirmed_id != exp_r.confirmed_id)
            report("confirmed_id", got_r.confirmed_id, exp_r.confirmed_id);
          if (got_r.has_confirm != exp_r.has_confirm)
            report("has_confirm", got_r.has_confirm, exp_r.has_confirm);
          if (got_r.cancel_edge != exp_r.cancel_edge)
            report("cancel_edge", got_r.cancel_edge, exp_r.cancel_edge);
          if (got_r.list_overflow != exp_r.list_overflow)
            report("list_overflow", got_r.list_overflow, exp_r.list_overflow);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
  end

endmodule

FILE: dv/directional_focus_navigator_tb.sv
// testbench top for the directional focus navigator: clock, reset, stimulus
// and verdict; checking is done by directional_focus_navigator_checker
// depends on dfn_pkg, dfn_if, the block and the checker
module directional_focus_navigator_tb;

  localparam int NUM_ITEMS   = 1250;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_WAIT  = 600;
  localparam int NAV_W       = dfn_pkg::NAV_W;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, items;
  int   send_idle_pct, recv_idle_pct;
  int   rect_x[8], rect_y[8], rect_w[8], rect_h[8];
  int   rect_n;

  dfn_in_if  in_if ();
  dfn_out_if out_if ();

  directional_focus_navigator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  directional_focus_navigator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .out_if       (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic send(dfn_pkg::cmd_e cmd, int id, int x, int y, int w, int h,
                      logic btn, logic [NAV_W-1:0] nav, logic conf, logic canc);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.cmd            <= cmd;
    in_if.target_id      <= id[15:0];
    in_if.pos_x          <= x[15:0];
    in_if.pos_y          <= y[15:0];
    in_if.size_w         <= w[14:0];
    in_if.size_h         <= h[14:0];
    in_if.button_primary <= btn;
    in_if.nav_bits       <= nav;
    in_if.confirm_held   <= conf;
    in_if.cancel_held    <= canc;
    do @(posedge clk_i); while (!in_if.ready);
    items++;
  endtask

  task automatic add_rect(int id, int x, int y, int w, int h);
    if (rect_n < 8) begin
      rect_x[rect_n] = x;
      rect_y[rect_n] = y;
      rect_w[rect_n] = w;
      rect_h[rect_n] = h;
      rect_n++;
    end
    send(dfn_pkg::CMD_ADD, id, x, y, w, h, 1'($urandom), NAV_W'($urandom),
         1'($urandom), 1'($urandom));
  endtask

  task automatic sample(int x, int y, logic btn, logic [NAV_W-1:0] nav, logic conf,
                        logic canc);
    send(dfn_pkg::CMD_SAMPLE, $urandom, x, y, $urandom, $urandom, btn, nav, conf, canc);
  endtask

  task automatic end_list();
    send(dfn_pkg::CMD_END, $urandom, $urandom, $urandom, $urandom, $urandom,
         1'($urandom), NAV_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_frame();
    int n, k, x, y, w, h;
    if ($urandom_range(0, 9) < 6) begin
      if ($urandom_range(0, 9) != 0) begin
        send(dfn_pkg::CMD_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom,
             1'($urandom), NAV_W'($urandom), 1'($urandom), 1'($urandom));
        rect_n = 0;
      end
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          x = $urandom; y = $urandom; w = $urandom; h = $urandom;
        end else begin
          x = $urandom_range(0, 200) - 100;
          y = $urandom_range(0, 200) - 100;
          w = $urandom_range(0, 60);
          h = $urandom_range(0, 60);
        end
        add_rect($urandom_range(0, 15) == 0 ? $urandom_range(0, 3) : $urandom, x, y, w, h);
      end
    end
    repeat ($urandom_range(1, 3)) begin
      k = $urandom_range(0, 9);
      if (k < 5 && rect_n > 0) begin
        n = $urandom_range(0, rect_n - 1);
        x = rect_x[n] + ((rect_w[n] > 0) ? $urandom_range(0, rect_w[n] - 1) : 0);
        y = rect_y[n] + ((rect_h[n] > 0) ? $urandom_range(0, rect_h[n] - 1) : 0);
      end else if (k < 8) begin
        x = $urandom_range(0, 200) - 100;
        y = $urandom_range(0, 200) - 100;
      end else begin
        x = $urandom;
        y = $urandom;
      end
      sample(x, y, 1'($urandom), NAV_W'($urandom), 1'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 7) == 0 ? 2 : 1) end_list();
    end
    if ($urandom_range(0, 9) == 0)
      send(dfn_pkg::cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
           $urandom, 1'($urandom), NAV_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    in_if.valid          = 1'b0;
    in_if.cmd            = dfn_pkg::CMD_SAMPLE;
    in_if.target_id      = '0;
    in_if.pos_x          = '0;
    in_if.pos_y          = '0;
    in_if.size_w         = '0;
    in_if.size_h         = '0;
    in_if.button_primary = 1'b0;
    in_if.nav_bits       = '0;
    in_if.confirm_held   = 1'b0;
    in_if.cancel_held    = 1'b0;
    items         = 0;
    rect_n        = 0;
    send_idle_pct = 15;
    recv_idle_pct = 68;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // end before any sample, then add without begin and duplicate ids
    end_list();
    add_rect(16'hffff, -32768, -32768, 32767, 0);
    add_rect(0, 32767, 32767, 0, 32767);
    add_rect(16'hffff, 10, 10, 20, 20);
    end_list();
    sample(0, 0, 1'b0, 4'b0010, 1'b0, 1'b0);
    end_list();
    end_list();
    sample(0, 0, 1'b0, 4'b1101, 1'b1, 1'b1);
    end_list();
    sample(15, 15, 1'b1, 4'b0000, 1'b1, 1'b0);
    end_list();
    sample(32767, -32768, 1'b0, 4'b1111, 1'b0, 1'b1);
    end_list();
    sample(-5, -5, 1'b1, 4'b0000, 1'b1, 1'b0);
    end_list();
    send(dfn_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 1'b0, 4'b0000, 1'b0, 1'b0);
    rect_n = 0;
    end_list();
    sample(1, 1, 1'b0, 4'b0001, 1'b1, 1'b0);
    end_list();

    while (items < NUM_ITEMS) begin
      if (items > NUM_ITEMS / 3 && send_idle_pct == 15) begin
        wait_drained();
        send_idle_pct = 68;
        recv_idle_pct = 15;
      end else if (items > 2 * NUM_ITEMS / 3 && send_idle_pct == 68) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_frame();
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
